// ----- hw/rtl/lcdns_pkg.sv -----
// shared types and constants for the character lcd nibble sequencer
`timescale 1ns / 1ps

package lcdns_pkg;

  // request operation codes
  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_PUT_CHAR  = 3'd1,
    OP_GOTO      = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_BACKLIGHT = 3'd4
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BYTE_WAIT  = 2'd0,
    CFG_CLEAR_WAIT = 2'd1,
    CFG_POWER_WAIT = 2'd2,
    CFG_STEP_WAIT  = 2'd3
  } cfg_idx_e;

  // what the back end has to run for one queued command
  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_BYTE,
    CMD_BACKLIGHT
  } cmd_kind_e;

  localparam int unsigned WaitW = 16;
  localparam int unsigned EvtWaitW = 17;

  localparam logic [7:0] LcdFuncSet = 8'h28;
  localparam logic [7:0] LcdDispOn  = 8'h0C;
  localparam logic [7:0] LcdClear   = 8'h01;
  localparam logic [7:0] LcdEntry   = 8'h06;
  localparam logic [7:0] LcdDdram   = 8'h80;

  localparam logic [3:0] NibWake    = 4'h3;
  localparam logic [3:0] NibFourBit = 4'h2;

  localparam logic [WaitW-1:0] ByteWaitRst  = 16'd80;
  localparam logic [WaitW-1:0] ClearWaitRst = 16'd2000;
  localparam logic [WaitW-1:0] PowerWaitRst = 16'd30000;
  localparam logic [WaitW-1:0] StepWaitRst  = 16'd5000;

  typedef struct packed {
    logic [WaitW-1:0] byte_wait;
    logic [WaitW-1:0] clear_wait;
    logic [WaitW-1:0] power_wait;
    logic [WaitW-1:0] step_wait;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       sel;
    logic       bl;
    logic       clr;
    logic [7:0] byte_val;
  } cmd_t;

  typedef struct packed {
    logic [3:0]          nib;
    logic                sel;
    logic                bl;
    logic                strobe;
    logic [EvtWaitW-1:0] wait_us;
    logic                last;
  } evt_t;

endpackage

// ----- hw/rtl/lcdns_fifo.sv -----
// small first-in first-out queue of fixed-width beats
`timescale 1ns / 1ps

module lcdns_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/lcdns_front.sv -----
// request decoder: turns an operation into a queued command record
`timescale 1ns / 1ps

module lcdns_front (
  input  logic [2:0]      op_i,
  input  logic [7:0]      data_i,
  output logic            cmd_valid_o,
  output lcdns_pkg::cmd_t cmd_o
);

  always_comb begin
    cmd_valid_o    = 1'b1;
    cmd_o.kind     = lcdns_pkg::CMD_BYTE;
    cmd_o.sel      = 1'b0;
    cmd_o.bl       = (data_i != 8'd0);
    cmd_o.clr      = 1'b0;
    cmd_o.byte_val = data_i;
    case (op_i)
      lcdns_pkg::OP_INIT: begin
        cmd_o.kind = lcdns_pkg::CMD_INIT;
      end
      lcdns_pkg::OP_PUT_CHAR: begin
        cmd_o.sel = 1'b1;
      end
      lcdns_pkg::OP_GOTO: begin
        // wraps mod 256
        cmd_o.byte_val = lcdns_pkg::LcdDdram + data_i;
      end
      lcdns_pkg::OP_CLEAR: begin
        cmd_o.byte_val = lcdns_pkg::LcdClear;
        cmd_o.clr      = 1'b1;
      end
      lcdns_pkg::OP_BACKLIGHT: begin
        cmd_o.kind = lcdns_pkg::CMD_BACKLIGHT;
      end
      default: begin
        // unknown ops are taken and dropped
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/lcdns_back.sv -----
// event sequencer: command to pin events, one per unstalled cycle
`timescale 1ns / 1ps

module lcdns_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcdns_pkg::cfg_t cfg_i,
  input  lcdns_pkg::cmd_t cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  input  logic            evt_full_i,
  output logic            evt_push_o,
  output lcdns_pkg::evt_t evt_o
);

  typedef enum logic [2:0] {
    W_NONE,
    W_POWER,
    W_STEP,
    W_BYTE,
    W_CLEAR
  } wait_sel_e;

  localparam logic [3:0] InitLastStep = 4'd12;
  localparam logic [3:0] InitByteStep = 4'd5;

  logic [3:0] step_q, step_d;
  logic [3:0] nib_q;
  logic       sel_q;
  logic       bl_q;
  logic       fire;
  logic [2:0] ib_idx;
  logic [7:0] ib_byte;
  wait_sel_e  wsel;

  assign fire       = !cmd_empty_i && !evt_full_i;
  assign evt_push_o = fire;
  assign cmd_pop_o  = fire && evt_o.last;
  assign ib_idx     = 3'(step_q - InitByteStep);

  always_comb begin
    case (ib_idx[2:1])
      2'd0:    ib_byte = lcdns_pkg::LcdFuncSet;
      2'd1:    ib_byte = lcdns_pkg::LcdDispOn;
      2'd2:    ib_byte = lcdns_pkg::LcdClear;
      default: ib_byte = lcdns_pkg::LcdEntry;
    endcase
  end

  always_comb begin
    evt_o.nib    = nib_q;
    evt_o.sel    = cmd_i.sel;
    evt_o.bl     = bl_q;
    evt_o.strobe = 1'b1;
    evt_o.last   = 1'b0;
    wsel         = W_NONE;
    case (cmd_i.kind)
      lcdns_pkg::CMD_INIT: begin
        evt_o.last = (step_q == InitLastStep);
        case (step_q)
          4'd0: begin
            // power-on wait, no strobe; nibble and backlight unchanged
            evt_o.strobe = 1'b0;
            wsel         = W_POWER;
          end
          4'd1: begin
            evt_o.nib = lcdns_pkg::NibWake;
            wsel      = W_POWER;
          end
          4'd2, 4'd3: begin
            evt_o.nib = lcdns_pkg::NibWake;
            wsel      = W_STEP;
          end
          4'd4: begin
            evt_o.nib = lcdns_pkg::NibFourBit;
            wsel      = W_STEP;
          end
          default: begin
            if (!ib_idx[0]) begin
              evt_o.nib = ib_byte[7:4];
            end else begin
              evt_o.nib = ib_byte[3:0];
              wsel      = (ib_byte == lcdns_pkg::LcdClear) ? W_CLEAR : W_BYTE;
            end
          end
        endcase
      end
      lcdns_pkg::CMD_BYTE: begin
        if (!step_q[0]) begin
          evt_o.nib = cmd_i.byte_val[7:4];
        end else begin
          evt_o.nib  = cmd_i.byte_val[3:0];
          evt_o.last = 1'b1;
          wsel       = cmd_i.clr ? W_CLEAR : W_BYTE;
        end
      end
      default: begin
        evt_o.sel    = sel_q;
        evt_o.bl     = cmd_i.bl;
        evt_o.strobe = 1'b0;
        evt_o.last   = 1'b1;
      end
    endcase

    case (wsel)
      W_POWER: evt_o.wait_us = {1'b0, cfg_i.power_wait};
      W_STEP:  evt_o.wait_us = {1'b0, cfg_i.step_wait};
      W_BYTE:  evt_o.wait_us = {1'b0, cfg_i.byte_wait};
      W_CLEAR: evt_o.wait_us = {1'b0, cfg_i.byte_wait} + {1'b0, cfg_i.clear_wait};
      default: evt_o.wait_us = '0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = evt_o.last ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      nib_q  <= '0;
      sel_q  <= 1'b0;
      bl_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      if (fire) begin
        nib_q <= evt_o.nib;
        sel_q <= evt_o.sel;
        bl_q  <= evt_o.bl;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (evt_push_o && evt_o.last))
    else $error("command retired without its last beat");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= InitLastStep)
    else $error("sequencer step out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_push_o |-> !evt_full_i)
    else $error("event pushed into full queue");

  a_step_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (step_q == 4'd0))
    else $error("step not cleared after command retired");
`endif

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer_core.sv -----
// top level of the character lcd nibble sequencer
`timescale 1ns / 1ps

// Drives a 4-bit character LCD. Each request (init, put character, goto, clear,
// backlight) is pushed into a command queue and expanded by the sequencer into
// pin events that come out of a result queue, one event per clock cycle while
// the result queue has room: init gives 13 events, put character, goto and
// clear give 2, backlight gives 1, and unknown ops are taken and give none.
// The single event sequencer works on one request at a time; a new request is
// taken every cycle while the command queue is not full. Timing registers may
// only be written while no request is in flight.
module char_lcd_nibble_sequencer_core #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned EvtDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  data_nibble_o,
  output logic        reg_select_o,
  output logic        backlight_o,
  output logic        strobe_res_o,
  output logic [16:0] wait_us_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  lcdns_pkg::cfg_t cfg_q;
  lcdns_pkg::cmd_t front_cmd, head_cmd;
  lcdns_pkg::evt_t back_evt, out_evt;
  logic            front_valid;
  logic            cmd_empty, cmd_pop;
  logic            evt_full, evt_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_wait  <= lcdns_pkg::ByteWaitRst;
      cfg_q.clear_wait <= lcdns_pkg::ClearWaitRst;
      cfg_q.power_wait <= lcdns_pkg::PowerWaitRst;
      cfg_q.step_wait  <= lcdns_pkg::StepWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdns_pkg::CFG_BYTE_WAIT:  cfg_q.byte_wait  <= cfg_wdata_i;
        lcdns_pkg::CFG_CLEAR_WAIT: cfg_q.clear_wait <= cfg_wdata_i;
        lcdns_pkg::CFG_POWER_WAIT: cfg_q.power_wait <= cfg_wdata_i;
        lcdns_pkg::CFG_STEP_WAIT:  cfg_q.step_wait  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lcdns_front u_front (
    .op_i        (op_i),
    .data_i      (data_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  lcdns_fifo #(
    .Width ($bits(lcdns_pkg::cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && front_valid),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (head_cmd),
    .empty_o (cmd_empty)
  );

  lcdns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (head_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .evt_full_i  (evt_full),
    .evt_push_o  (evt_push),
    .evt_o       (back_evt)
  );

  lcdns_fifo #(
    .Width ($bits(lcdns_pkg::evt_t)),
    .Depth (EvtDepth)
  ) u_evt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .wdata_i (back_evt),
    .full_o  (evt_full),
    .pop_i   (pop),
    .rdata_o (out_evt),
    .empty_o (empty)
  );

  assign data_nibble_o = out_evt.nib;
  assign reg_select_o  = out_evt.sel;
  assign backlight_o   = out_evt.bl;
  assign strobe_res_o  = out_evt.strobe;
  assign wait_us_o     = out_evt.wait_us;
  assign last_o        = out_evt.last;

endmodule
